>>> sv/sitda_pkg.sv
package sitda_pkg;

    // decimal digits of a 32-bit magnitude
    localparam int NUM_DIGITS = 10;
    localparam int DIG_IDX_W  = 4;

    // divide by ten through the reciprocal, exact for any 32-bit value
    localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // one converted value, digits least significant first
    typedef struct packed {
        logic                           neg;
        logic [DIG_IDX_W-1:0]           ndig;
        logic [NUM_DIGITS-1:0][3:0]     digits;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef enum logic [1:0] {
        F_IDLE,
        F_CONV,
        F_PUSH
    } t_front_state;

    typedef enum logic {
        B_IDLE,
        B_EMIT
    } t_back_state;

endpackage

>>> sv/sitda_front.sv
module sitda_front import sitda_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  logic signed [31:0] i_value,
    input  t_q_status          i_q_status,
    output logic               o_q_push,
    output t_entry             o_entry
);

    t_front_state         r_state, n_state;
    logic [31:0]          r_mag;
    logic [DIG_IDX_W-1:0] r_cnt;
    t_entry               r_entry;

    logic [63:0] w_prod;
    logic [31:0] w_quot;
    logic [3:0]  w_q10;
    logic [3:0]  w_digit;
    logic        w_last;
    logic        w_accept;
    logic [31:0] w_mag_in;

    // quotient by reciprocal multiply, remainder from the low nibble only
    assign w_prod  = 64'(r_mag) * 64'(RECIP_TEN);
    assign w_quot  = 32'(w_prod >> RECIP_SHIFT);
    assign w_q10   = {w_quot[0], 3'b000} + {w_quot[2:0], 1'b0};
    assign w_digit = r_mag[3:0] - w_q10;
    assign w_last  = (w_quot == 32'd0) || (r_cnt == DIG_IDX_W'(NUM_DIGITS - 1));

    assign w_mag_in = i_value[31] ? (32'd0 - $unsigned(i_value)) : $unsigned(i_value);
    assign w_accept = i_push && !o_full;

    always_comb begin
        o_full   = 1'b1;
        o_q_push = 1'b0;
        unique case (r_state)
            F_IDLE: begin
                o_full = 1'b0;
            end
            F_CONV: begin
                o_full = 1'b1;
            end
            F_PUSH: begin
                o_full   = i_q_status.full;
                o_q_push = !i_q_status.full;
            end
            default: begin
                o_full = 1'b1;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: begin
                if (w_accept) n_state = F_CONV;
            end
            F_CONV: begin
                if (w_last) n_state = F_PUSH;
            end
            F_PUSH: begin
                if (!i_q_status.full) n_state = w_accept ? F_CONV : F_IDLE;
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mag       <= w_mag_in;
            r_entry.neg <= i_value[31];
            r_cnt       <= '0;
        end else if (r_state == F_CONV) begin
            r_entry.digits[r_cnt] <= w_digit;
            r_mag                 <= w_quot;
            r_cnt                 <= r_cnt + 1'b1;
            if (w_last) r_entry.ndig <= r_cnt + 1'b1;
        end
    end

    assign o_entry = r_entry;

endmodule

>>> sv/sitda_queue.sv
module sitda_queue import sitda_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_entry    i_entry,
    input  logic      i_pop,
    output t_entry    o_entry,
    output t_q_status o_status
);

    t_entry            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_status.full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_entry        = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_entry;
    end

endmodule

>>> sv/sitda_back.sv
module sitda_back import sitda_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_q_status  i_q_status,
    input  t_entry     i_entry,
    output logic       o_q_pop,
    output logic       o_empty,
    input  logic       i_pop,
    output logic [7:0] o_character,
    output logic       o_final_char
);

    t_back_state                r_state, n_state;
    logic [NUM_DIGITS-1:0][3:0] r_digits;
    logic                       r_sign;
    logic [DIG_IDX_W-1:0]       r_idx;

    logic w_take;
    logic w_done;
    logic w_load;

    assign w_take = i_pop && !o_empty;
    assign w_done = w_take && !r_sign && (r_idx == '0);
    assign w_load = !i_q_status.empty && ((r_state == B_IDLE) || w_done);

    always_comb begin
        o_empty      = 1'b1;
        o_q_pop      = w_load;
        o_character  = r_sign ? CHAR_MINUS : CHAR_ZERO + {4'b0000, r_digits[r_idx]};
        o_final_char = !r_sign && (r_idx == '0);
        unique case (r_state)
            B_IDLE:  o_empty = 1'b1;
            B_EMIT:  o_empty = 1'b0;
            default: o_empty = 1'b1;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (w_load) n_state = B_EMIT;
            end
            B_EMIT: begin
                if (w_done) n_state = w_load ? B_EMIT : B_IDLE;
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // most significant digit first, sign ahead of it
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_digits <= i_entry.digits;
            r_sign   <= i_entry.neg;
            r_idx    <= i_entry.ndig - 1'b1;
        end else if (w_take) begin
            if (r_sign) begin
                r_sign <= 1'b0;
            end else begin
                r_idx <= r_idx - 1'b1;
            end
        end
    end

endmodule

>>> sv/signed_int_to_decimal_ascii.sv
// channel  | direction | handshake          | payload
// ---------+-----------+--------------------+------------------------------------
// input    | in        | push / full        | i_value (32-bit signed)
// result   | out       | empty / pop        | o_character (8-bit), o_final_char
//
// front: takes a value, then works out one decimal digit per step (1 to 10),
//   the queue write overlapping the next value's accept
// back: one character per beat (1 to 11), a queued next text starts with no gap
// reset: synchronous, active low, clears front, queue and back control
// either side stalls alone; a two-entry queue holds converted values between them
module signed_int_to_decimal_ascii import sitda_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [31:0] i_value,
    output logic               empty,
    input  logic               pop,
    output logic [7:0]         o_character,
    output logic               o_final_char
);

    // front to queue
    logic      w_q_push;
    t_entry    w_front_entry;
    // queue to back
    logic      w_q_pop;
    t_entry    w_back_entry;
    t_q_status w_q_status;

    // sign and magnitude, then repeated divide by ten, digits least significant first
    sitda_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_value    (i_value),
        .i_q_status (w_q_status),
        .o_q_push   (w_q_push),
        .o_entry    (w_front_entry)
    );

    // short queue of converted values so front and back stall independently
    sitda_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_q_push),
        .i_entry  (w_front_entry),
        .i_pop    (w_q_pop),
        .o_entry  (w_back_entry),
        .o_status (w_q_status)
    );

    // walks the digits back out as ascii, one beat per character
    sitda_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_status   (w_q_status),
        .i_entry      (w_back_entry),
        .o_q_pop      (w_q_pop),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_character  (o_character),
        .o_final_char (o_final_char)
    );

    // queue never written while full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_push |-> !w_q_status.full)
        else $error("queue written while full");

    // queue never read while empty
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> !w_q_status.empty)
        else $error("queue read while empty");

    // a shown character is a sign or a decimal digit
    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_character == CHAR_MINUS)
                || ((o_character >= CHAR_ZERO) && (o_character <= CHAR_NINE)))
        else $error("character outside sign and digits");

    // the sign is always followed by at least one digit
    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_character == CHAR_MINUS)) |-> !o_final_char)
        else $error("sign marked as final character");

endmodule

>>> sim/tb_signed_int_to_decimal_ascii.sv
module tb_signed_int_to_decimal_ascii import sitda_pkg::*;;

    // run limit, far beyond the slowest correct run
    localparam int CYCLE_LIMIT = 400000;
    // quiet cycles after the last character before the verdict
    localparam int DRAIN_CYCLES = 24;
    localparam int RANDOM_PER_PHASE = 80;

    // one expected character of a value's text
    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } t_text_char;

    // works out the decimal text of each accepted value and checks the
    // characters that come out against it, oldest first
    class ascii_text_board;
        t_text_char expected_text[$];
        int         mismatches;

        function new();
            mismatches = 0;
        endfunction

        // two's complement to sign and magnitude, then digits lsd first
        function void add_value(logic [31:0] value);
            logic [31:0] mag;
            logic [3:0]  digs[10];
            int          nd;
            t_text_char  ch;
            nd  = 0;
            mag = value[31] ? (32'd0 - value) : value;
            // the most negative value wraps to 2^31, still right as unsigned
            do begin
                digs[nd] = 4'(mag % 32'd10);
                nd++;
                mag = mag / 32'd10;
            end while (mag != 32'd0 && nd < 10);
            if (value[31]) begin
                ch.code = CHAR_MINUS;
                ch.last = 1'b0;
                expected_text.push_back(ch);
            end
            for (int i = nd - 1; i >= 0; i--) begin
                ch.code = CHAR_ZERO + {4'd0, digs[i]};
                ch.last = (i == 0);
                expected_text.push_back(ch);
            end
        endfunction

        function void check_char(logic [7:0] code, logic last);
            t_text_char exp_ch;
            if (expected_text.size() == 0) begin
                $error("unexpected character beat: character %0d final_char %0b",
                       code, last);
                mismatches++;
                return;
            end
            exp_ch = expected_text.pop_front();
            if (code !== exp_ch.code) begin
                $error("character: expected %0d actual %0d", exp_ch.code, code);
                mismatches++;
            end
            if (last !== exp_ch.last) begin
                $error("final_char: expected %0b actual %0b", exp_ch.last, last);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_text.size();
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               push;
    logic               full;
    logic signed [31:0] i_value;
    logic               empty;
    logic               pop;
    logic [7:0]         o_character;
    logic               o_final_char;

    ascii_text_board board;
    int              cycle_count;
    // idle chances in percent for the sender and the receiver
    int              push_idle_pct;
    int              pop_idle_pct;

    signed_int_to_decimal_ascii DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_value      (i_value),
        .empty        (empty),
        .pop          (pop),
        .o_character  (o_character),
        .o_final_char (o_final_char)
    );

    always #6 i_clk = ~i_clk;

    // watchdog: a stuck handshake or missing characters end here
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("signed_int_to_decimal_ascii test failed");
            $finish;
        end
    end

    // receiver: pop changes on the falling edge, stalls at random
    always @(negedge i_clk) begin
        pop <= i_rst_n && ($urandom_range(0, 99) >= pop_idle_pct);
    end

    // result monitor: a character beat moves when pop is high and empty low
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            board.check_char(o_character, o_final_char);
        end
    end

    // one input beat; entered and left on a falling edge, push is set once per
    // edge so a back-to-back beat keeps push high without a glitch
    task automatic send_value(input logic [31:0] value);
        while ($urandom_range(0, 99) < push_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push    <= 1'b1;
        i_value <= value;
        do @(posedge i_clk); while (full);
        board.add_value(value);
        @(negedge i_clk);
    endtask

    // mix of full-width words and magnitudes of every digit count, either sign
    function automatic logic [31:0] random_value();
        logic [31:0] mag;
        if ($urandom_range(0, 9) < 3) begin
            return $urandom;
        end
        mag = $urandom >> $urandom_range(0, 31);
        return $urandom_range(0, 1) ? (32'd0 - mag) : mag;
    endfunction

    task automatic run_random(input int count);
        repeat (count) send_value(random_value());
    endtask

    initial begin
        logic [31:0] directed[$];
        board         = new();
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        push          = 1'b0;
        pop           = 1'b0;
        i_value       = '0;
        cycle_count   = 0;
        push_idle_pct = 34;
        pop_idle_pct  = 74;

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // zero, single digits, powers of ten on both sides, the extremes
        // and the most negative value with its wrapped magnitude
        directed = '{32'd0, 32'd1, -32'sd1, 32'd9, -32'sd9, 32'd10, -32'sd10,
                     32'd99, 32'd100, -32'sd100, 32'd999999999, 32'd1000000000,
                     -32'sd1000000000, 32'd123456789, -32'sd123456789,
                     32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
                     32'h5555_5555, 32'hAAAA_AAAA, 32'd4294967286};
        foreach (directed[i]) send_value(directed[i]);

        // sender idles lightly, receiver heavily: the queue backs up
        run_random(RANDOM_PER_PHASE);

        // the other way round: the back end starves
        push_idle_pct = 74;
        pop_idle_pct  = 34;
        run_random(RANDOM_PER_PHASE);

        // full rate on both sides
        push_idle_pct = 0;
        pop_idle_pct  = 0;
        run_random(RANDOM_PER_PHASE);
        push <= 1'b0;

        // let every expected character come out, then watch for strays
        while (board.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (board.mismatches == 0) begin
            $display("signed_int_to_decimal_ascii test passed");
        end else begin
            $display("signed_int_to_decimal_ascii test failed");
        end
        $finish;
    end

endmodule
